>>> rtl/core/lss_pkg.sv
`default_nettype none
package lss_pkg;

   localparam int unsigned IdentWords = 4;
   localparam int unsigned IdentWidth = 32;
   localparam int unsigned CsrIndexWidth = 2;

   // register indexes on the csr port
   localparam logic [CsrIndexWidth-1:0] CsrVendor   = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrProduct  = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrRevision = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CsrSerial   = 2'd3;

   // command specifiers
   localparam logic [7:0] CmdSwitchGlobal = 8'h04;
   localparam logic [7:0] CmdConfigNodeId = 8'h11;
   localparam logic [7:0] CmdConfigBitTim = 8'h13;
   localparam logic [7:0] CmdActivateBit  = 8'h15;
   localparam logic [7:0] CmdStore        = 8'h17;
   localparam logic [7:0] CmdSelVendor    = 8'h40;
   localparam logic [7:0] CmdSelProduct   = 8'h41;
   localparam logic [7:0] CmdSelRevision  = 8'h42;
   localparam logic [7:0] CmdSelSerial    = 8'h43;
   localparam logic [7:0] RspSelDone      = 8'h44;
   localparam logic [7:0] CmdIdentFirst   = 8'h46;
   localparam logic [7:0] CmdIdentLast    = 8'h4B;
   localparam logic [7:0] RspFastscan     = 8'h4F;
   localparam logic [7:0] CmdFastscan     = 8'h51;
   localparam logic [7:0] CmdInqVendor    = 8'h5A;
   localparam logic [7:0] CmdInqProduct   = 8'h5B;
   localparam logic [7:0] CmdInqRevision  = 8'h5C;
   localparam logic [7:0] CmdInqSerial    = 8'h5D;

   localparam logic [7:0] ScanStart   = 8'h80;
   localparam logic [7:0] ScanLost    = 8'hFF;
   localparam logic [7:0] NodeUnset   = 8'hFF;
   localparam logic [7:0] NodeMax     = 8'd127;
   localparam logic [7:0] ScanSubMax  = 8'd3;
   localparam logic [7:0] ScanBitsMax = 8'd31;
   localparam logic [IdentWidth-1:0] WordOnes = 32'hFFFF_FFFF;

   localparam logic [7:0] StatusOk  = 8'd0;
   localparam logic [7:0] StatusErr = 8'd1;

   typedef logic [IdentWords-1:0][IdentWidth-1:0] ident_type;

   typedef struct packed {
      logic       mode;
      logic [7:0] node_id;
      logic [2:0] sel_stage;
      logic [7:0] scan_pos;
   } state_type;

   typedef struct packed {
      logic [7:0] command_code;
      logic [7:0] byte_one;
      logic [7:0] byte_two;
      logic [7:0] byte_three;
      logic [7:0] byte_four;
      logic [7:0] bits_checked;
      logic [7:0] scan_sub;
      logic [7:0] scan_next;
   } frame_type;

   typedef struct packed {
      logic       send_reply;
      logic [7:0] reply_code;
      logic [7:0] reply_one;
      logic [7:0] reply_two;
      logic [7:0] reply_three;
      logic [7:0] reply_four;
      logic       slave_mode_now;
      logic [7:0] node_id_now;
      logic       accepted;
   } rsp_type;

endpackage
`default_nettype wire

>>> rtl/core/lss_decode.sv
`default_nettype none
module lss_decode (
   input  wire lss_pkg::state_type cur,
   input  wire lss_pkg::frame_type frm,
   input  wire lss_pkg::ident_type ident,
   output lss_pkg::state_type      nxt,
   output lss_pkg::rsp_type        rsp
);

   logic [31:0] word;
   logic [31:0] mask;
   logic [31:0] sub_word;
   logic [31:0] step_word;
   logic [1:0]  inq_index;
   logic [31:0] inq_word;
   logic        scan_hit;
   logic        cfg;

   assign word      = {frm.byte_four, frm.byte_three, frm.byte_two, frm.byte_one};
   assign mask      = lss_pkg::WordOnes << frm.bits_checked[4:0];
   assign sub_word  = ident[frm.scan_sub[1:0]];
   assign step_word = ident[frm.command_code[1:0]];
   // inquire codes start at 0x5A, so the word index is offset from the low code bits
   assign inq_index = frm.command_code[1:0] - lss_pkg::CmdInqVendor[1:0];
   assign inq_word  = ident[inq_index];
   assign cfg       = cur.mode;
   // out-of-range index or bit count never matches
   assign scan_hit  = (frm.scan_sub <= lss_pkg::ScanSubMax)
                    && (frm.bits_checked <= lss_pkg::ScanBitsMax)
                    && ((sub_word & mask) == (word & mask));

   always_comb begin
      nxt = cur;
      rsp = '0;
      unique case (frm.command_code) inside
         lss_pkg::CmdFastscan: begin
            if (cur.node_id == lss_pkg::NodeUnset) begin
               nxt.mode = 1'b0;
               if (frm.bits_checked == lss_pkg::ScanStart) begin
                  nxt.scan_pos   = '0;
                  rsp.send_reply = 1'b1;
                  rsp.accepted   = 1'b1;
                  rsp.reply_code = lss_pkg::RspFastscan;
               end else if (cur.scan_pos == frm.scan_sub) begin
                  if (scan_hit) begin
                     // last word fully matched: enter configuration
                     if (frm.bits_checked == 8'd0 && frm.scan_next < frm.scan_sub) begin
                        nxt.mode = 1'b1;
                     end
                     nxt.scan_pos   = frm.scan_next;
                     rsp.send_reply = 1'b1;
                     rsp.accepted   = 1'b1;
                     rsp.reply_code = lss_pkg::RspFastscan;
                  end else if (frm.scan_sub != frm.scan_next) begin
                     nxt.scan_pos = lss_pkg::ScanLost;
                  end
               end
            end
         end
         lss_pkg::CmdSwitchGlobal: begin
            if (frm.byte_one <= 8'd1) begin
               nxt.mode     = frm.byte_one[0];
               rsp.accepted = 1'b1;
            end
         end
         [lss_pkg::CmdSelVendor:lss_pkg::CmdSelSerial]: begin
            nxt.mode     = 1'b0;
            rsp.accepted = 1'b1;
            if (cur.sel_stage == {1'b0, frm.command_code[1:0]} && word == step_word) begin
               if (frm.command_code == lss_pkg::CmdSelSerial) begin
                  nxt.mode       = 1'b1;
                  nxt.sel_stage  = '0;
                  rsp.send_reply = 1'b1;
                  rsp.reply_code = lss_pkg::RspSelDone;
                  rsp.reply_one  = 8'd1;
               end else begin
                  nxt.sel_stage = {1'b0, frm.command_code[1:0]} + 3'd1;
               end
            end else begin
               nxt.sel_stage = '0;
            end
         end
         lss_pkg::CmdConfigNodeId: begin
            if (cfg) begin
               rsp.send_reply = 1'b1;
               rsp.reply_code = lss_pkg::CmdConfigNodeId;
               if (frm.byte_one >= 8'd1 && frm.byte_one <= lss_pkg::NodeMax) begin
                  nxt.node_id   = frm.byte_one;
                  rsp.reply_one = lss_pkg::StatusOk;
                  rsp.accepted  = 1'b1;
               end else begin
                  rsp.reply_one = lss_pkg::StatusErr;
               end
            end
         end
         lss_pkg::CmdConfigBitTim, lss_pkg::CmdStore: begin
            if (cfg) begin
               rsp.send_reply = 1'b1;
               rsp.reply_code = frm.command_code;
               rsp.reply_one  = lss_pkg::StatusErr;
            end
         end
         lss_pkg::CmdActivateBit: begin
         end
         [lss_pkg::CmdInqVendor:lss_pkg::CmdInqSerial]: begin
            if (cfg) begin
               rsp.send_reply  = 1'b1;
               rsp.accepted    = 1'b1;
               rsp.reply_code  = frm.command_code;
               rsp.reply_one   = inq_word[7:0];
               rsp.reply_two   = inq_word[15:8];
               rsp.reply_three = inq_word[23:16];
               rsp.reply_four  = inq_word[31:24];
            end
         end
         [lss_pkg::CmdIdentFirst:lss_pkg::CmdIdentLast]: begin
            rsp.accepted = 1'b1;
         end
         default: begin
         end
      endcase
      rsp.slave_mode_now = nxt.mode;
      rsp.node_id_now    = nxt.node_id;
   end

endmodule
`default_nettype wire

>>> rtl/core/lss_slave_command_engine.sv
// LSS slave command engine.
// Latency: a result beat is presented the cycle after its request beat is taken.
// Throughput: one frame per cycle when not stalled; decode is before the result register.
// req_ready stays high while the result register is empty or being drained.
// Synchronous reset: waiting mode, node-ID 255, no selective progress, scan position 0,
// identity words 0, no result pending.
`default_nettype none
module lss_slave_command_engine (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  wire [7:0]  req_command_code,
   input  wire [7:0]  req_byte_one,
   input  wire [7:0]  req_byte_two,
   input  wire [7:0]  req_byte_three,
   input  wire [7:0]  req_byte_four,
   input  wire [7:0]  req_bits_checked,
   input  wire [7:0]  req_scan_sub,
   input  wire [7:0]  req_scan_next,
   output logic       rsp_valid,
   input  wire        rsp_ready,
   output logic       rsp_send_reply,
   output logic [7:0] rsp_reply_code,
   output logic [7:0] rsp_reply_one,
   output logic [7:0] rsp_reply_two,
   output logic [7:0] rsp_reply_three,
   output logic [7:0] rsp_reply_four,
   output logic       rsp_slave_mode_now,
   output logic [7:0] rsp_node_id_now,
   output logic       rsp_accepted,
   input  wire        csr_wr_en,
   input  wire [lss_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire [lss_pkg::IdentWidth-1:0]    csr_wdata
);

   lss_pkg::state_type state_ff;
   lss_pkg::state_type state_in;
   lss_pkg::rsp_type   rsp_ff;
   lss_pkg::rsp_type   rsp_in;
   lss_pkg::ident_type ident_ff;
   lss_pkg::frame_type frame;
   logic               rsp_valid_ff;
   logic               take;

   assign frame = '{command_code: req_command_code, byte_one: req_byte_one,
                    byte_two: req_byte_two, byte_three: req_byte_three,
                    byte_four: req_byte_four, bits_checked: req_bits_checked,
                    scan_sub: req_scan_sub, scan_next: req_scan_next};

   lss_decode u_decode (
      .cur   (state_ff),
      .frm   (frame),
      .ident (ident_ff),
      .nxt   (state_in),
      .rsp   (rsp_in)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode      <= 1'b0;
         state_ff.node_id   <= lss_pkg::NodeUnset;
         state_ff.sel_stage <= '0;
         state_ff.scan_pos  <= '0;
         rsp_valid_ff       <= 1'b0;
         ident_ff           <= '0;
      end else begin
         if (take) begin
            state_ff <= state_in;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               lss_pkg::CsrVendor:   ident_ff[0] <= csr_wdata;
               lss_pkg::CsrProduct:  ident_ff[1] <= csr_wdata;
               lss_pkg::CsrRevision: ident_ff[2] <= csr_wdata;
               lss_pkg::CsrSerial:   ident_ff[3] <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_send_reply     = rsp_ff.send_reply;
   assign rsp_reply_code     = rsp_ff.reply_code;
   assign rsp_reply_one      = rsp_ff.reply_one;
   assign rsp_reply_two      = rsp_ff.reply_two;
   assign rsp_reply_three    = rsp_ff.reply_three;
   assign rsp_reply_four     = rsp_ff.reply_four;
   assign rsp_slave_mode_now = rsp_ff.slave_mode_now;
   assign rsp_node_id_now    = rsp_ff.node_id_now;
   assign rsp_accepted       = rsp_ff.accepted;

endmodule
`default_nettype wire
